// ===== design/ckbb_pkg.sv =====
package ckbb_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 800;
   localparam int SCREEN_HEIGHT_DEFAULT = 480;

   localparam logic [7:0] KEY_TRANSPARENT = 8'hFF;

   // register indexes on the csr port
   localparam logic [1:0] CSR_DEST_X     = 2'd0;
   localparam logic [1:0] CSR_DEST_Y     = 2'd1;
   localparam logic [1:0] CSR_SRC_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_SRC_HEIGHT = 2'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] src_byte0;
      logic [7:0] src_byte1;
      logic [7:0] src_byte2;
      logic [7:0] src_byte3;
   } ckbb_req_type;

   typedef struct packed {
      logic        write_enable;
      logic [18:0] write_address;
      logic [31:0] write_pixel;
      logic        out_of_bounds;
      logic        last_pixel;
   } ckbb_rsp_type;

   // classified pixel on its way from front to back
   typedef struct packed {
      logic        write_enable;
      logic [9:0]  row_sum;
      logic [10:0] col_sum;
      logic [31:0] write_pixel;
      logic        out_of_bounds;
      logic        last_pixel;
   } ckbb_job_type;

endpackage

// ===== design/ckbb_front.sv =====
module ckbb_front import ckbb_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [9:0]   csr_write_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  ckbb_req_type req_payload,
   input  logic         push_ready,
   output logic         push_valid,
   output ckbb_job_type push_job
);

   localparam logic [12:0] SCREEN_W = 13'(SCREEN_WIDTH);
   localparam logic [12:0] SCREEN_H = 13'(SCREEN_HEIGHT);

   logic [9:0] dest_x_ff, dest_x_in;
   logic [8:0] dest_y_ff, dest_y_in;
   logic [9:0] src_width_ff, src_width_in;
   logic [8:0] src_height_ff, src_height_in;
   logic [9:0] column_count_ff, column_count_in;
   logic [8:0] row_count_ff, row_count_in;

   logic        take;
   logic        empty_image;
   logic        oob;
   logic [9:0]  col;
   logic [8:0]  row;
   logic [10:0] col_next;
   logic [9:0]  row_next;
   logic        row_wrap;
   logic        col_wrap;

   assign req_ready  = push_ready;
   assign take       = req_valid && push_ready;
   assign push_valid = take;

   always_comb begin
      dest_x_in     = dest_x_ff;
      dest_y_in     = dest_y_ff;
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEST_X:     dest_x_in     = csr_write_data;
            CSR_DEST_Y:     dest_y_in     = csr_write_data[8:0];
            CSR_SRC_WIDTH:  src_width_in  = csr_write_data;
            CSR_SRC_HEIGHT: src_height_in = csr_write_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      empty_image = (src_width_ff == '0) || (src_height_ff == '0);
      oob = ({2'b0, 11'(src_width_ff) + 11'(dest_x_ff)} > SCREEN_W) ||
            ({3'b0, 10'(src_height_ff) + 10'(dest_y_ff)} > SCREEN_H);

      // a counter beyond a shrunk size restarts at zero
      col = (column_count_ff < src_width_ff) ? column_count_ff : '0;
      row = (row_count_ff < src_height_ff) ? row_count_ff : '0;

      col_next = 11'(col) + 11'd1;
      row_next = 10'(row) + 10'd1;
      col_wrap = col_next >= 11'(src_width_ff);
      row_wrap = row_next >= 10'(src_height_ff);

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (take) begin
         if (empty_image) begin
            column_count_in = '0;
            row_count_in    = '0;
         end else if (col_wrap) begin
            column_count_in = '0;
            row_count_in    = row_wrap ? 9'd0 : row_next[8:0];
         end else begin
            column_count_in = col_next[9:0];
            row_count_in    = row;
         end
      end

      push_job.write_pixel   = {req_payload.src_byte3, req_payload.src_byte0,
                                req_payload.src_byte1, req_payload.src_byte2};
      push_job.out_of_bounds = oob;
      push_job.write_enable  = !empty_image && !oob &&
                               (req_payload.src_byte3 != KEY_TRANSPARENT);
      push_job.last_pixel    = !empty_image && col_wrap && row_wrap;
      push_job.row_sum       = 10'(row) + 10'(dest_y_ff);
      push_job.col_sum       = 11'(col) + 11'(dest_x_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff       <= '0;
         dest_y_ff       <= '0;
         src_width_ff    <= '0;
         src_height_ff   <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         dest_x_ff       <= dest_x_in;
         dest_y_ff       <= dest_y_in;
         src_width_ff    <= src_width_in;
         src_height_ff   <= src_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

endmodule

// ===== design/ckbb_queue.sv =====
module ckbb_queue import ckbb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  ckbb_job_type push_job,
   input  logic         pop,
   output logic         head_valid,
   output ckbb_job_type head_job
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   ckbb_job_type entry_ff [QUEUE_DEPTH];

   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != COUNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/ckbb_back.sv =====
module ckbb_back import ckbb_pkg::*; #(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  ckbb_job_type head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ckbb_rsp_type rsp_payload
);

   localparam logic [12:0] SCREEN_W = 13'(SCREEN_WIDTH);

   logic         rsp_valid_ff, rsp_valid_in;
   ckbb_rsp_type rsp_ff, rsp_in;
   logic [22:0]  row_base;

   // advance when the output register is empty or its transfer completes
   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      row_base = 23'(head_job.row_sum) * 23'(SCREEN_W);

      rsp_in.write_enable  = head_job.write_enable;
      rsp_in.write_address = head_job.write_enable ?
                             (row_base[18:0] + 19'(head_job.col_sum)) : '0;
      rsp_in.write_pixel   = head_job.write_pixel;
      rsp_in.out_of_bounds = head_job.out_of_bounds;
      rsp_in.last_pixel    = head_job.last_pixel;

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/color_keyed_bitmap_blit_unit.sv =====
// Color-keyed bitmap blit. Source pixels enter on the req_ channel in row
// order, top row first, one four-byte pixel per transfer. Each pixel leaves
// on the rsp_ channel as one frame buffer write: the repacked 32-bit word,
// its word address (row + dest_y) * SCREEN_WIDTH + column + dest_x, and a
// write enable that is low for the transparent key (byte3 = 0xFF), for an
// empty image and for one that does not fit on the screen (out_of_bounds
// set). last_pixel marks the final pixel of the image.
// The csr_ port writes dest_x, dest_y, src_width and src_height; write it
// only while no pixel is in flight.
// Each pixel passes through the queue and then the output register before
// rsp_valid rises. Throughput is one pixel per cycle while the receiver
// accepts, set by the front classifier and the back address multiply, each
// taking one pixel per cycle, with a 2-entry queue between.
// When the receiver stalls, the output register holds and the queue fills;
// req_ready drops once the queue is full and rises the cycle after the
// back takes an entry from it.
// Reset clears the csr registers, counters and rsp_valid to zero and empties the queue.
module color_keyed_bitmap_blit_unit import ckbb_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [9:0]   csr_write_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  ckbb_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ckbb_rsp_type rsp_payload
);

   logic         push_valid;
   logic         push_ready;
   ckbb_job_type push_job;
   logic         head_valid;
   ckbb_job_type head_job;
   logic         pop;

   ckbb_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .push_ready       (push_ready),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   ckbb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ckbb_back #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
